[sv/gsv_pkg.sv]
// ----------------------------------------------------------------------------
// gsv_pkg: shared definitions for the grouped sample variance core
// Sizes, status codes and sequencer states used by the core and its divider.
// ----------------------------------------------------------------------------
package gsv_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W       = 32 + ADDR_W;
  localparam int ACC_W       = 64 + ADDR_W;
  localparam int DIV_W       = 64;
  localparam int VAR_W       = 40;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_FEW = 2'd1;
  localparam logic [1:0] STATUS_OVF = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_WALK,
    ST_VAR_GO,
    ST_VAR_WAIT
  } state_t;

endpackage

[sv/grouped_sample_variance_core.sv]
// ----------------------------------------------------------------------------
// grouped_sample_variance_core: two-pass sample variance of one group
// Keeps the samples of the target group, then forms the mean, sums squared
// deviations and divides by count minus one with a shared iterative divider.
//
//   Channel   Ports                                   Beat marked by
//   input     sample, group_label, last               start & !busy
//   result    variance, matching_count, status        done (one cycle)
//   config    target_group                            target_group_we
//
// An item that does not close a set, or closes one with fewer than two kept
// samples, is taken with busy staying low. A closing item with n >= 2 kept
// samples holds busy through two divider passes (mean and variance) and a
// pipelined walk of the sample memory, one read per cycle. Reset is
// synchronous and clears all counters and the running sum.
// The result receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module grouped_sample_variance_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] sample,
  input  logic [7:0]  group_label,
  input  logic        last,
  input  logic        target_group_we,
  input  logic [7:0]  target_group,
  output logic        done,
  output logic [39:0] variance,
  output logic [12:0] matching_count,
  output logic [1:0]  status
);
  import gsv_pkg::*;

  state_t state, state_next;

  logic [31:0]             mem [MAX_SAMPLES];
  logic [31:0]             rd_data;
  logic [7:0]              group_sel;
  logic signed [SUM_W-1:0] running_sum;
  logic [CNT_W-1:0]        kept_count;
  logic                    overflow_seen;

  logic                    accept, match, room, keep;
  logic [CNT_W-1:0]        cnt_new;
  logic signed [SUM_W-1:0] sum_new;
  logic                    ovf_new;

  logic signed [32:0]      mean;
  logic [CNT_W-1:0]        issue_idx;
  logic                    issue;
  logic                    rd_valid, mag_valid, prod_valid;
  logic [31:0]             mag;
  logic [63:0]             prod;
  logic [ACC_W-1:0]        acc;
  logic signed [33:0]      dev;
  logic [SUM_W-1:0]        sum_mag;

  logic                    div_start, div_done;
  logic [DIV_W-1:0]        div_dividend, div_quotient;
  logic [CNT_W-1:0]        div_divisor;

  assign busy    = state != ST_IDLE;
  assign accept  = start && !busy;
  assign match   = group_label == group_sel;
  assign room    = kept_count < CNT_W'(MAX_SAMPLES);
  assign keep    = accept && match && room;
  assign cnt_new = kept_count + CNT_W'(keep);
  assign sum_new = keep ? running_sum + SUM_W'(signed'(sample)) : running_sum;
  assign ovf_new = overflow_seen || (accept && match && !room);
  assign issue   = (state == ST_WALK) && (issue_idx < kept_count);
  assign dev     = 34'(signed'(rd_data)) - 34'(mean);
  assign sum_mag = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);

  gsv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = DIV_W'(sum_mag);
    div_divisor  = kept_count;
    case (state)
      ST_IDLE: begin
        if (accept && last && cnt_new >= CNT_W'(2)) begin
          state_next = ST_MEAN_GO;
        end
      end
      ST_MEAN_GO: begin
        div_start  = 1'b1;
        state_next = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!issue && !rd_valid && !mag_valid && !prod_valid) begin
          state_next = ST_VAR_GO;
        end
      end
      ST_VAR_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(acc >> 16);
        div_divisor  = kept_count - CNT_W'(1);
        state_next   = ST_VAR_WAIT;
      end
      ST_VAR_WAIT: begin
        if (div_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      mem[kept_count[ADDR_W-1:0]] <= sample;
    end
    rd_data <= mem[issue_idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    mag  <= dev[33] ? 32'(-dev) : 32'(dev);
    prod <= mag * mag;
    if (rst) begin
      group_sel     <= '0;
      running_sum   <= '0;
      kept_count    <= '0;
      overflow_seen <= 1'b0;
      done          <= 1'b0;
      rd_valid      <= 1'b0;
      mag_valid     <= 1'b0;
      prod_valid    <= 1'b0;
      issue_idx     <= '0;
    end else begin
      done       <= 1'b0;
      rd_valid   <= issue;
      mag_valid  <= rd_valid;
      prod_valid <= mag_valid;
      if (prod_valid) begin
        acc <= acc + ACC_W'(prod);
      end
      if (target_group_we) begin
        group_sel <= target_group;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (last && cnt_new < CNT_W'(2)) begin
              done           <= 1'b1;
              variance       <= '0;
              status         <= STATUS_FEW;
              matching_count <= 13'(cnt_new);
              running_sum    <= '0;
              kept_count     <= '0;
              overflow_seen  <= 1'b0;
            end else begin
              running_sum   <= sum_new;
              kept_count    <= cnt_new;
              overflow_seen <= ovf_new;
            end
          end
        end
        ST_MEAN_WAIT: begin
          if (div_done) begin
            mean      <= running_sum[SUM_W-1] ? -33'(div_quotient) : 33'(div_quotient);
            issue_idx <= '0;
            acc       <= '0;
          end
        end
        ST_WALK: begin
          if (issue) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end
        end
        ST_VAR_WAIT: begin
          if (div_done) begin
            done           <= 1'b1;
            variance       <= (div_quotient[DIV_W-1:VAR_W] != '0) ? {VAR_W{1'b1}}
                                                                  : div_quotient[VAR_W-1:0];
            status         <= overflow_seen ? STATUS_OVF : STATUS_OK;
            matching_count <= 13'(kept_count);
            running_sum    <= '0;
            kept_count     <= '0;
            overflow_seen  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[sv/gsv_div.sv]
// ----------------------------------------------------------------------------
// gsv_div: iterative unsigned divider
// Restoring division of a 64-bit dividend by a count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module gsv_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [gsv_pkg::DIV_W-1:0] dividend,
  input  logic [gsv_pkg::CNT_W-1:0] divisor,
  output logic [gsv_pkg::DIV_W-1:0] quotient,
  output logic                      done
);
  import gsv_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);

  logic              running;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  dvsr;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem, quotient[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        step     <= '0;
        quotient <= dividend;
        dvsr     <= divisor;
        rem      <= '0;
      end else if (running) begin
        rem      <= fits ? CNT_W'(trial - {1'b0, dvsr}) : CNT_W'(trial);
        quotient <= {quotient[DIV_W-2:0], fits};
        step     <= step + STEP_W'(1);
        if (step == STEP_W'(DIV_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the grouped sample variance core
// Sets of samples with mixed group labels are sent under several target
// groups. Each set is also folded into a bench-side copy of the group state,
// and every closing beat yields the expected variance, count and status. The
// core's result strobes are checked against these in order.
// ----------------------------------------------------------------------------
module tb_top;
  import gsv_pkg::*;

  localparam int          SETTLE_CYCLES = 200;
  localparam int          PHASE_ITEMS   = 230;
  localparam logic [127:0] VAR_CEIL     = (128'd1 << VAR_W) - 128'd1;

  typedef struct packed {
    logic [31:0] sample;
    logic [7:0]  label;
    logic        last;
  } sample_beat_t;

  typedef struct packed {
    logic [VAR_W-1:0] variance;
    logic [12:0]      matching_count;
    logic [1:0]       status;
  } var_result_t;

  logic        clk;
  logic        rst;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] sample = '0;
  logic [7:0]  group_label = '0;
  logic        last = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_value = '0;
  logic        done;
  logic [39:0] variance;
  logic [12:0] matching_count;
  logic [1:0]  status;

  sample_beat_t pending_beats[$];
  var_result_t  expected_results[$];
  int           beats_in_flight = 0;
  int           errors = 0;
  logic         beat_taken = 1'b0;
  logic         no_gaps = 1'b0;

  logic [31:0]  kept_samples[MAX_SAMPLES];
  longint       group_sum;
  int           kept_n;
  logic         store_overflow;
  logic [7:0]   group_sel;

  grouped_sample_variance_core uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .sample         (sample),
    .group_label    (group_label),
    .last           (last),
    .target_group_we(cfg_we),
    .target_group   (cfg_value),
    .done           (done),
    .variance       (variance),
    .matching_count (matching_count),
    .status         (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Folds one accepted beat into the group state; returns 1 when it closes a set.
  function automatic bit fold_group_sample(input sample_beat_t b, output var_result_t r);
    longint       mean_q;
    longint       dev;
    logic [63:0]  mag;
    logic [127:0] sq_sum;
    logic [127:0] quot;
    int           idx;
    r = '0;
    if (b.label == group_sel) begin
      if (kept_n < MAX_SAMPLES) begin
        kept_samples[kept_n] = b.sample;
        group_sum += longint'($signed(b.sample));
        kept_n++;
      end else begin
        store_overflow = 1'b1;
      end
    end
    if (!b.last) return 1'b0;
    r.matching_count = 13'(kept_n);
    if (kept_n < 2) begin
      r.variance = '0;
      r.status = STATUS_FEW;
    end else begin
      mean_q = group_sum / longint'(kept_n);
      sq_sum = '0;
      for (idx = 0; idx < kept_n; idx++) begin
        dev = longint'($signed(kept_samples[idx])) - mean_q;
        mag = (dev < 0) ? 64'(-dev) : 64'(dev);
        sq_sum += 128'(mag) * 128'(mag);
      end
      quot = (sq_sum >> 16) / 128'(kept_n - 1);
      r.variance = (quot > VAR_CEIL) ? '1 : quot[VAR_W-1:0];
      r.status = store_overflow ? STATUS_OVF : STATUS_OK;
    end
    group_sum = 0;
    kept_n = 0;
    store_overflow = 1'b0;
    return 1'b1;
  endfunction

  always @(negedge clk) begin : drive
    sample_beat_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (pending_beats.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 6)) begin
        nxt = pending_beats.pop_front();
        start <= 1'b1;
        sample <= nxt.sample;
        group_label <= nxt.label;
        last <= nxt.last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch
    sample_beat_t b;
    var_result_t  r;
    var_result_t  want;
    if (rst) begin
      beat_taken <= 1'b0;
      group_sum = 0;
      kept_n = 0;
      store_overflow = 1'b0;
      group_sel = '0;
    end else begin
      beat_taken <= start && !busy;
      if (start && !busy) begin
        b = '{sample: sample, label: group_label, last: last};
        beats_in_flight--;
        if (fold_group_sample(b, r)) expected_results.push_back(r);
      end
      if (cfg_we) group_sel = cfg_value;
      if (done) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: variance %0h count %0d status %0d",
                   $time, variance, matching_count, status);
        end else begin
          want = expected_results.pop_front();
          if (variance !== want.variance) begin
            errors++;
            $display("%0t: variance expected %0h actual %0h", $time, want.variance, variance);
          end
          if (matching_count !== want.matching_count) begin
            errors++;
            $display("%0t: matching_count expected %0d actual %0d",
                     $time, want.matching_count, matching_count);
          end
          if (status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          end
        end
      end
    end
  end

  function automatic void push_beat(input logic [31:0] s, input logic [7:0] lbl,
                                    input logic l);
    pending_beats.push_back('{sample: s, label: lbl, last: l});
    beats_in_flight++;
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 32'h1FFFF) - 32'h10000;
      2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      3: return $urandom_range(0, 32'h1FFFFF) - 32'h100000 + 32'h00500000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] other_label(input logic [7:0] tgt);
    logic [7:0] lbl;
    do lbl = 8'($urandom_range(0, 255)); while (lbl == tgt);
    return lbl;
  endfunction

  function automatic int queue_random_set(input logic [7:0] tgt);
    int n;
    int pick;
    int match_pct;
    pick = $urandom_range(0, 99);
    if (pick < 10) n = 1;
    else if (pick < 80) n = $urandom_range(2, 12);
    else if (pick < 95) n = $urandom_range(13, 40);
    else n = $urandom_range(41, 120);
    match_pct = ($urandom_range(0, 9) == 0) ? 10 : 75;
    for (int k = 0; k < n; k++)
      push_beat(pick_sample(),
                ($urandom_range(0, 99) < match_pct) ? tgt : other_label(tgt),
                k == n - 1);
    return n;
  endfunction

  task automatic wait_idle();
    do @(negedge clk); while (beats_in_flight != 0 || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_target(input logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_value <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] tgt;
    int         queued;
    wait (!rst);
    @(negedge clk);
    tgt = 8'd0;

    push_beat(32'h00000005, 8'd7, 1'b1);
    push_beat(32'h7FFFFFFF, 8'd0, 1'b1);
    push_beat(32'h7FFFFFFF, 8'd0, 1'b0);
    push_beat(32'h80000000, 8'd0, 1'b1);
    push_beat(32'h00010000, 8'd0, 1'b0);
    push_beat(32'h00030000, 8'd0, 1'b0);
    push_beat(32'hFFFF0000, 8'd200, 1'b0);
    push_beat(32'h00020000, 8'd0, 1'b0);
    push_beat(32'h00000000, 8'd9, 1'b1);
    push_beat(32'h12345678, 8'd0, 1'b0);
    push_beat(32'h12345678, 8'd0, 1'b1);
    push_beat(32'hFFFFFFFF, 8'd0, 1'b0);
    push_beat(32'hFFFFFFFE, 8'd0, 1'b0);
    push_beat(32'hFFFFFFFC, 8'd0, 1'b1);
    push_beat(32'hFFFFFFFF, 8'd255, 1'b0);
    push_beat(32'h80000000, 8'd0, 1'b0);
    push_beat(32'h80000000, 8'd0, 1'b0);
    push_beat(32'h7FFFFFFF, 8'd128, 1'b1);
    wait_idle();

    // A set that fills the store exactly, then one that runs past it.
    for (int k = 0; k < MAX_SAMPLES; k++)
      push_beat(pick_sample(), tgt, k == MAX_SAMPLES - 1);
    for (int k = 0; k < MAX_SAMPLES + 2; k++)
      push_beat(pick_sample(), tgt, 1'b0);
    push_beat(pick_sample(), 8'd77, 1'b1);

    // This set stays open across the next target change.
    push_beat(32'h00040000, tgt, 1'b0);
    push_beat(32'hFFFC0000, tgt, 1'b0);
    push_beat(32'h00008000, 8'd255, 1'b0);
    wait_idle();

    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 0) tgt = 8'd255;
      else if (phase == 4) tgt = 8'd0;
      else tgt = 8'($urandom_range(0, 255));
      set_target(tgt);
      no_gaps <= (phase == 2);
      queued = 0;
      while (queued < PHASE_ITEMS) queued += queue_random_set(tgt);
      wait_idle();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
